// ===== design/hhfs_pkg.sv =====
// ----------------------------------------------------------------------------
// hhfs_pkg: shared types and constants of the header field scanner
// Byte codes, status codes and the records that pass between the front end,
// the scan engine and the output queue.
// ----------------------------------------------------------------------------
package hhfs_pkg;

  // widths of the result fields
  localparam int unsigned OffW    = 12;
  localparam int unsigned HdrNumW = 5;
  localparam int unsigned StatusW = 2;

  // byte codes the scanner reacts to
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;

  // final status codes
  typedef enum logic [StatusW-1:0] {
    StSuccess   = 2'd0,
    StMalformed = 2'd1,
    StTooMany   = 2'd2
  } status_e;

  // result kinds
  localparam logic KindHeader = 1'b0;
  localparam logic KindStatus = 1'b1;

  // classified byte handed from the front end to the scan engine
  typedef struct packed {
    logic            scan;      // byte is judged by the scanner
    logic            overlong;  // byte lies beyond the buffer limit
    logic            last;      // final byte of the buffer
    logic            crlf;      // judged byte and its successor are CR LF
    logic            term;      // the two bytes after that are CR LF too
    logic            colon;
    logic            space;
    logic [OffW-1:0] pos;       // position of the judged byte
  } item_t;

  // one result record
  typedef struct packed {
    logic               kind;
    status_e            status;
    logic [HdrNumW-1:0] number;
    logic [OffW-1:0]    name_off;
    logic [OffW-1:0]    name_len;
    logic [OffW-1:0]    value_off;
    logic [OffW-1:0]    value_len;
    logic               final_res;
  } result_t;

endpackage

// ===== design/hhfs_if.sv =====
// ----------------------------------------------------------------------------
// hhfs channel interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hhfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink (input valid, data_byte, end_of_buffer, output ready);
endinterface

interface hhfs_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [1:0]  parse_status;
  logic [4:0]  header_number;
  logic [11:0] name_offset;
  logic [11:0] name_length;
  logic [11:0] value_offset;
  logic [11:0] value_length;
  logic        final_result;

  modport source (
    output valid, result_kind, parse_status, header_number, name_offset,
           name_length, value_offset, value_length, final_result,
    input  ready
  );
  modport sink (
    input  valid, result_kind, parse_status, header_number, name_offset,
           name_length, value_offset, value_length, final_result,
    output ready
  );
endinterface

// ===== design/http_header_field_scanner.sv =====
// ----------------------------------------------------------------------------
// http_header_field_scanner: HTTP header field tokeniser
// Streams a request buffer a byte per beat and reports header offsets.
// ----------------------------------------------------------------------------
// in_i carries one buffer byte per beat, end_of_buffer marking the last one.
// out_o carries result records: one header record per header closed by a
// CR LF (name and value offsets and lengths, value offset after the spaces
// following the colon), and one status record with final_result set on the
// last byte of each buffer. Bytes up to the first CR LF are skipped.
// Throughput: one byte per cycle while the queues have room. A final byte
// that both closes the last header and ends the buffer is held in the scan
// engine while its two records go out one per cycle.
// A two-entry queue between intake and scan engine and a two-entry result
// queue let either side stall; when out_o stalls, beats keep flowing until
// the result queue holds two records, the item queue then fills up,
// and in_i drops ready.
// Reset clears all queues and scanner state; the block then waits for the
// first byte of a new buffer. After each status record it is back in that
// state for the next buffer.
// ----------------------------------------------------------------------------
module http_header_field_scanner #(
  parameter int unsigned MAX_HEADERS      = 32,
  parameter int unsigned MAX_BUFFER_BYTES = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  hhfs_in_if.sink         in_i,
  hhfs_out_if.source      out_o
);

  localparam int unsigned ItemW = $bits(hhfs_pkg::item_t);
  localparam int unsigned ResW  = $bits(hhfs_pkg::result_t);

  hhfs_pkg::item_t   fr_item, bk_item;
  logic              fr_valid, fr_ready, bk_valid, bk_ready;
  hhfs_pkg::result_t bk_res, out_res;
  logic              res_valid, res_ready;

  // byte intake and classification
  hhfs_front #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .data_byte_i    (in_i.data_byte),
    .end_of_buffer_i(in_i.end_of_buffer),
    .q_valid_o      (fr_valid),
    .q_ready_i      (fr_ready),
    .q_item_o       (fr_item)
  );

  // queue between intake and scan engine
  hhfs_fifo #(
    .Width(ItemW),
    .Depth(2)
  ) u_item_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fr_valid),
    .in_ready_o (fr_ready),
    .in_data_i  (fr_item),
    .out_valid_o(bk_valid),
    .out_ready_i(bk_ready),
    .out_data_o (bk_item)
  );

  // scan engine
  hhfs_back #(
    .MAX_HEADERS(MAX_HEADERS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(bk_valid),
    .q_ready_o(bk_ready),
    .q_item_i (bk_item),
    .r_valid_o(res_valid),
    .r_ready_i(res_ready),
    .r_data_o (bk_res)
  );

  // result queue, registered output side
  hhfs_fifo #(
    .Width(ResW),
    .Depth(2)
  ) u_res_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_ready_o (res_ready),
    .in_data_i  (bk_res),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_data_o (out_res)
  );

  // result beat fields
  assign out_o.result_kind   = out_res.kind;
  assign out_o.parse_status  = out_res.status;
  assign out_o.header_number = out_res.number;
  assign out_o.name_offset   = out_res.name_off;
  assign out_o.name_length   = out_res.name_len;
  assign out_o.value_offset  = out_res.value_off;
  assign out_o.value_length  = out_res.value_len;
  assign out_o.final_result  = out_res.final_res;

endmodule

// ===== design/hhfs_fifo.sv =====
// ----------------------------------------------------------------------------
// hhfs_fifo: small flop based queue
// Ring of registers with valid/ready on both sides; full throughput when
// pushing and popping in the same cycle.
// ----------------------------------------------------------------------------
module hhfs_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != CntW'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

endmodule

// ===== design/hhfs_front.sv =====
// ----------------------------------------------------------------------------
// hhfs_front: byte intake and classification
// Keeps the three-byte lookahead window, the byte position and the search
// for the end of the request line, and classifies each byte for the scanner.
// ----------------------------------------------------------------------------
module hhfs_front #(
  parameter int unsigned MAX_BUFFER_BYTES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_buffer_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output hhfs_pkg::item_t     q_item_o
);

  localparam int unsigned PosW = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int unsigned OffW = hhfs_pkg::OffW;

  // line search phases
  localparam logic [1:0] PhSeek = 2'd0;
  localparam logic [1:0] PhWait = 2'd1;
  localparam logic [1:0] PhScan = 2'd2;

  logic [23:0]        win_q, win_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [1:0]         phase_q, phase_d;
  logic               accept, overlong;
  logic [PosW+OffW-1:0] pos_wide;
  logic [7:0]         c0, c1, c2;

  assign in_ready_o = q_ready_i;
  assign q_valid_o  = in_valid_i;
  assign accept     = in_valid_i && q_ready_i;
  assign overlong   = (pos_q >= PosW'(MAX_BUFFER_BYTES));
  assign pos_wide   = {{OffW{1'b0}}, pos_q};
  assign c0         = win_q[23:16];
  assign c1         = win_q[15:8];
  assign c2         = win_q[7:0];

  // classify the byte three places back
  always_comb begin
    q_item_o.scan     = !overlong && (phase_q == PhScan);
    q_item_o.overlong = overlong;
    q_item_o.last     = end_of_buffer_i;
    q_item_o.crlf     = (c0 == hhfs_pkg::ChCr) && (c1 == hhfs_pkg::ChLf);
    q_item_o.term     = (c2 == hhfs_pkg::ChCr) && (data_byte_i == hhfs_pkg::ChLf);
    q_item_o.colon    = (c0 == hhfs_pkg::ChColon);
    q_item_o.space    = (c0 == hhfs_pkg::ChSpace);
    q_item_o.pos      = pos_wide[OffW-1:0] - OffW'(3);
  end

  // window, position and phase
  always_comb begin
    win_d   = win_q;
    pos_d   = pos_q;
    phase_d = phase_q;
    if (accept) begin
      if (end_of_buffer_i) begin
        win_d   = '0;
        pos_d   = '0;
        phase_d = PhSeek;
      end else begin
        win_d = {win_q[15:0], data_byte_i};
        if (!overlong) begin
          pos_d = pos_q + PosW'(1);
          unique case (phase_q)
            PhSeek: begin
              if ((c2 == hhfs_pkg::ChCr) && (data_byte_i == hhfs_pkg::ChLf)) begin
                phase_d = PhWait;
              end
            end
            PhWait:  phase_d = PhScan;
            default: phase_d = phase_q;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      pos_q   <= '0;
      phase_q <= PhSeek;
    end else begin
      win_q   <= win_d;
      pos_q   <= pos_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ===== design/hhfs_back.sv =====
// ----------------------------------------------------------------------------
// hhfs_back: header scan engine
// Runs the border, name, colon and value scanner on classified beats and
// writes header records and the final status to the result queue.
// ----------------------------------------------------------------------------
module hhfs_back #(
  parameter int unsigned MAX_HEADERS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  hhfs_pkg::item_t     q_item_i,
  output logic                r_valid_o,
  input  logic                r_ready_i,
  output hhfs_pkg::result_t   r_data_o
);

  localparam int unsigned HcW  = $clog2(MAX_HEADERS + 1);
  localparam int unsigned OffW = hhfs_pkg::OffW;
  localparam int unsigned NumW = hhfs_pkg::HdrNumW;

  // scanner states
  localparam logic [1:0] ScBorder = 2'd0;
  localparam logic [1:0] ScName   = 2'd1;
  localparam logic [1:0] ScColon  = 2'd2;
  localparam logic [1:0] ScValue  = 2'd3;

  logic [1:0]        sstate_q, sstate_d, sstate_n;
  logic              acf_q, acf_d, acf_n;
  logic [OffW-1:0]   border_q, border_d, border_n;
  logic [OffW-1:0]   colon_q, colon_d, colon_n;
  logic [OffW-1:0]   space_q, space_d, space_n;
  logic [HcW-1:0]    hc_q, hc_d, hc_n;
  hhfs_pkg::status_e status_q, status_d, status_n;
  logic              done_q, done_d, done_n;
  logic              pend_q, pend_d;
  logic              hdr_emit, go;
  logic [HcW+NumW-1:0] num_wide;
  logic [OffW-1:0]   voff;
  hhfs_pkg::result_t hdr_rec, stat_rec;

  assign go = q_valid_i && r_ready_i;

  // scanner step on the current beat
  always_comb begin
    sstate_n = sstate_q;
    acf_n    = acf_q;
    border_n = border_q;
    colon_n  = colon_q;
    space_n  = space_q;
    hc_n     = hc_q;
    status_n = status_q;
    done_n   = done_q;
    hdr_emit = 1'b0;
    if (q_item_i.overlong) begin
      if (status_q == hhfs_pkg::StSuccess) begin
        status_n = hhfs_pkg::StMalformed;
      end
      done_n = 1'b1;
    end else if (q_item_i.scan && !done_q) begin
      priority if (q_item_i.crlf) begin
        if (sstate_q != ScBorder) begin
          status_n = hhfs_pkg::StMalformed;
          done_n   = 1'b1;
        end else if (hc_q >= HcW'(MAX_HEADERS)) begin
          status_n = hhfs_pkg::StTooMany;
          done_n   = 1'b1;
        end else begin
          hdr_emit = (hc_q != '0);
          if (q_item_i.term) begin
            done_n = 1'b1;
          end else begin
            border_n = q_item_i.pos;
            hc_n     = hc_q + HcW'(1);
            sstate_n = ScName;
          end
        end
      end else if (q_item_i.colon) begin
        if (sstate_q == ScName) begin
          status_n = hhfs_pkg::StMalformed;
          done_n   = 1'b1;
        end else if (sstate_q == ScColon) begin
          colon_n  = q_item_i.pos;
          space_n  = '0;
          sstate_n = ScValue;
          acf_n    = 1'b1;
        end
      end else if (q_item_i.space) begin
        if ((sstate_q != ScValue) && (sstate_q != ScBorder)) begin
          status_n = hhfs_pkg::StMalformed;
          done_n   = 1'b1;
        end else if (acf_q) begin
          space_n = space_q + OffW'(1);
        end
      end else begin
        if (sstate_q == ScName) begin
          sstate_n = ScColon;
        end else if (sstate_q == ScValue) begin
          sstate_n = ScBorder;
        end
        acf_n = 1'b0;
      end
    end
  end

  // header record from the state before this beat
  assign num_wide = {{NumW{1'b0}}, hc_q - HcW'(1)};
  assign voff     = colon_q + space_q + OffW'(1);

  always_comb begin
    hdr_rec.kind      = hhfs_pkg::KindHeader;
    hdr_rec.status    = hhfs_pkg::StSuccess;
    hdr_rec.number    = num_wide[NumW-1:0];
    hdr_rec.name_off  = border_q + OffW'(2);
    hdr_rec.name_len  = colon_q - border_q - OffW'(2);
    hdr_rec.value_off = voff;
    hdr_rec.value_len = q_item_i.pos - voff;
    hdr_rec.final_res = 1'b0;
  end

  // status record: after a split beat the state already holds the update
  always_comb begin
    stat_rec           = '0;
    stat_rec.kind      = hhfs_pkg::KindStatus;
    stat_rec.final_res = 1'b1;
    if (pend_q) begin
      stat_rec.status = done_q ? status_q : hhfs_pkg::StMalformed;
    end else begin
      stat_rec.status = done_n ? status_n : hhfs_pkg::StMalformed;
    end
  end

  // beat sequencing and result writes
  always_comb begin
    sstate_d  = sstate_q;
    acf_d     = acf_q;
    border_d  = border_q;
    colon_d   = colon_q;
    space_d   = space_q;
    hc_d      = hc_q;
    status_d  = status_q;
    done_d    = done_q;
    pend_d    = pend_q;
    q_ready_o = 1'b0;
    r_valid_o = 1'b0;
    r_data_o  = stat_rec;
    if (go) begin
      if (pend_q || (q_item_i.last && !hdr_emit)) begin
        // status closes the buffer, back to reset state
        r_valid_o = 1'b1;
        r_data_o  = stat_rec;
        q_ready_o = 1'b1;
        pend_d    = 1'b0;
        sstate_d  = ScBorder;
        acf_d     = 1'b0;
        border_d  = '0;
        colon_d   = '0;
        space_d   = '0;
        hc_d      = '0;
        status_d  = hhfs_pkg::StSuccess;
        done_d    = 1'b0;
      end else begin
        r_valid_o = hdr_emit;
        r_data_o  = hdr_rec;
        q_ready_o = !q_item_i.last;
        pend_d    = q_item_i.last;
        sstate_d  = sstate_n;
        acf_d     = acf_n;
        border_d  = border_n;
        colon_d   = colon_n;
        space_d   = space_n;
        hc_d      = hc_n;
        status_d  = status_n;
        done_d    = done_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sstate_q <= ScBorder;
      acf_q    <= 1'b0;
      border_q <= '0;
      colon_q  <= '0;
      space_q  <= '0;
      hc_q     <= '0;
      status_q <= hhfs_pkg::StSuccess;
      done_q   <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      sstate_q <= sstate_d;
      acf_q    <= acf_d;
      border_q <= border_d;
      colon_q  <= colon_d;
      space_q  <= space_d;
      hc_q     <= hc_d;
      status_q <= status_d;
      done_q   <= done_d;
      pend_q   <= pend_d;
    end
  end

  // a held status only waits on the final beat of a buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (q_valid_i && q_item_i.last))
    else $error("pending status without a final beat");

  // header count never passes the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q <= HcW'(MAX_HEADERS))
    else $error("header count beyond limit");

  // a written status record leaves the scanner in its reset state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_valid_o && r_ready_i && r_data_o.final_res) |=>
      (hc_q == '0) && !done_q && !pend_q && (sstate_q == ScBorder))
    else $error("scanner not cleared after status");

  // a split final beat always follows a header record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pend_q) |-> $past(r_valid_o && (r_data_o.kind == hhfs_pkg::KindHeader)))
    else $error("split beat without a header record");

endmodule
